/* hw/rtl/sba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types, codes and helpers of the sector bitmap allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int ADDR_W     = 28;
  localparam int SECT_CNT_W = 17;
  localparam int WORD_BITS  = 32;
  localparam int POS_W      = 5;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

  // Configuration register indexes
  localparam logic REG_PARTITION_BASE    = 1'b0;
  localparam logic REG_PARTITION_SECTORS = 1'b1;

  localparam logic [SECT_CNT_W-1:0] SECTORS_RESET = 17'h10000;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_SUM_CHK,
    ST_WORD_CHK,
    ST_FREE_CHK,
    ST_FREE_WR,
    ST_DONE
  } sba_state_t;

  typedef struct packed {
    logic map_rd;
    logic map_wr;
    logic sum_rd;
    logic sum_wr;
  } sba_mem_ctrl_t;

  typedef struct packed {
    logic start;
    logic advance;
    logic set_full;
    logic clr_full;
  } sba_flag_ctrl_t;

  typedef struct packed {
    logic hit;
    logic last;
  } sba_flag_stat_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } sba_fz_t;

  // Lowest clear bit of a 32-bit word.
  function automatic sba_fz_t first_zero(input logic [WORD_BITS-1:0] w);
    sba_fz_t r;
    r.found = 1'b0;
    r.pos   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r.found = 1'b1;
        r.pos   = POS_W'(i);
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/sba_map_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_map_store
// Used-bit map (one bit per sector) and word-full summary map, both
// synchronous single-port memories with registered read data.
// ----------------------------------------------------------------------------
module sba_map_store #(
  parameter int MAX_SECTORS = 65536
) (
  input  logic                                        clk,
  input  sba_pkg::sba_mem_ctrl_t                      ctrl,
  input  logic [((((MAX_SECTORS + 31) / 32) > 1) ?
                 $clog2((MAX_SECTORS + 31) / 32) : 1) - 1:0] map_addr,
  input  logic [sba_pkg::WORD_BITS-1:0]               map_wdata,
  output logic [sba_pkg::WORD_BITS-1:0]               map_rdata,
  input  logic [((((MAX_SECTORS + 1023) / 1024) > 1) ?
                 $clog2((MAX_SECTORS + 1023) / 1024) : 1) - 1:0] sum_addr,
  input  logic [sba_pkg::WORD_BITS-1:0]               sum_wdata,
  output logic [sba_pkg::WORD_BITS-1:0]               sum_rdata
);

  localparam int WORDS  = (MAX_SECTORS + 31) / 32;
  localparam int SWORDS = (WORDS + 31) / 32;

  logic [sba_pkg::WORD_BITS-1:0] map_mem [WORDS];
  logic [sba_pkg::WORD_BITS-1:0] sum_mem [SWORDS];

  always_ff @(posedge clk) begin
    if (ctrl.map_wr) begin
      map_mem[map_addr] <= map_wdata;
    end
    if (ctrl.map_rd) begin
      map_rdata <= map_mem[map_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_wr) begin
      sum_mem[sum_addr] <= sum_wdata;
    end
    if (ctrl.sum_rd) begin
      sum_rdata <= sum_mem[sum_addr];
    end
  end

endmodule

/* hw/rtl/sba_group_flags.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_group_flags
// One full flag per group of 32 bitmap words, and a chunked search for the
// lowest group that still has a free word (32 flags examined per cycle).
// ----------------------------------------------------------------------------
module sba_group_flags #(
  parameter int MAX_SECTORS = 65536
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sba_pkg::sba_flag_ctrl_t ctrl,
  input  logic [((((MAX_SECTORS + 1023) / 1024) > 1) ?
                 $clog2((MAX_SECTORS + 1023) / 1024) : 1) - 1:0] grp,
  output sba_pkg::sba_flag_stat_t stat,
  output logic [((((MAX_SECTORS + 1023) / 1024) > 1) ?
                 $clog2((MAX_SECTORS + 1023) / 1024) : 1) - 1:0] hit_grp
);

  localparam int WORDS      = (MAX_SECTORS + 31) / 32;
  localparam int SWORDS     = (WORDS + 31) / 32;
  localparam int SW_W       = (SWORDS > 1) ? $clog2(SWORDS) : 1;
  localparam int TOP_CHUNKS = (SWORDS + 31) / 32;
  localparam int TOP_BITS   = TOP_CHUNKS * 32;
  localparam int TB_W       = $clog2(TOP_BITS);
  localparam int TC_W       = (TOP_CHUNKS > 1) ? $clog2(TOP_CHUNKS) : 1;

  logic [TOP_BITS-1:0]           flags;
  logic [TC_W-1:0]               chunk;
  logic [sba_pkg::WORD_BITS-1:0] chunk_bits;
  sba_pkg::sba_fz_t              fz;

  // Padding flags past the last group reset to full and never change.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TOP_BITS; i++) begin
        flags[i] <= (i >= SWORDS);
      end
    end else if (ctrl.set_full) begin
      flags[TB_W'(grp)] <= 1'b1;
    end else if (ctrl.clr_full) begin
      flags[TB_W'(grp)] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= '0;
    end else if (ctrl.start) begin
      chunk <= '0;
    end else if (ctrl.advance) begin
      chunk <= chunk + TC_W'(1);
    end
  end

  always_comb begin
    chunk_bits = flags[{chunk, 5'b0} +: sba_pkg::WORD_BITS];
    fz         = sba_pkg::first_zero(chunk_bits);
    stat.hit   = fz.found;
    stat.last  = (chunk == TC_W'(TOP_CHUNKS - 1));
    hit_grp    = SW_W'({chunk, fz.pos});
  end

endmodule

/* hw/rtl/sector_bitmap_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_bitmap_allocator_top
// First-fit sector allocator over a three-level used map: word bitmap in
// memory, word-full summary in memory, group-full flags in flip-flops.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  ------------------------------
//  in        sink       in_valid / in_stall    command, sector
//  out       source     out_valid / out_stall  granted_sector, status
//  cfg       sink       cfg_we                 cfg_index, cfg_data
//
//  Steps: allocate runs the group flag search, which examines 32 group flags
//    per cycle over TOP_CHUNKS = ceil(MAX_SECTORS / 32768) chunks (2 at the
//    default), the summary word check, the bitmap word check and the result.
//    Free does an offset check with map reads, a write back, then the result.
//  One item is in work at a time; the next is taken once the result has
//    moved into the output register.
//  Reset: a clearing pass writes every bitmap and summary word to zero,
//    one word per cycle, ceil(MAX_SECTORS / 32) words (2048 at default);
//    in_stall holds high meanwhile. Configuration writes are taken always.
//  Stalls: out_stall only holds the output register; a finished result
//    waits in ST_DONE until the output register is free.
// ----------------------------------------------------------------------------
module sector_bitmap_allocator_top #(
  parameter int MAX_SECTORS = 65536
) (
  input  logic                        clk,
  input  logic                        rst,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        command,
  input  logic [sba_pkg::ADDR_W-1:0]  sector,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sba_pkg::ADDR_W-1:0]  granted_sector,
  output logic [1:0]                  status,
  // configuration
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [sba_pkg::ADDR_W-1:0]  cfg_data
);

  localparam int WORDS  = (MAX_SECTORS + 31) / 32;
  localparam int SWORDS = (WORDS + 31) / 32;
  localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SW_W   = (SWORDS > 1) ? $clog2(SWORDS) : 1;
  localparam logic [sba_pkg::ADDR_W-1:0] MAX_ADDR   = sba_pkg::ADDR_W'(MAX_SECTORS);
  localparam logic [sba_pkg::ADDR_W-1:0] WORDS_ADDR = sba_pkg::ADDR_W'(WORDS);
  localparam logic [sba_pkg::ADDR_W-1:0] SWORDS_ADDR = sba_pkg::ADDR_W'(SWORDS);

  // Configuration registers
  logic [sba_pkg::ADDR_W-1:0]     partition_base;
  logic [sba_pkg::SECT_CNT_W-1:0] partition_sectors;

  // Control and working registers
  sba_pkg::sba_state_t           state, state_next;
  logic [WORD_W-1:0]             clr_idx;
  logic [sba_pkg::ADDR_W-1:0]    off;
  logic [SW_W-1:0]               grp;
  logic [WORD_W-1:0]             word;
  logic [sba_pkg::WORD_BITS-1:0] sum_word;
  logic [sba_pkg::ADDR_W-1:0]    res_granted;
  logic [1:0]                    res_status;

  // Combinational control
  sba_pkg::sba_mem_ctrl_t        mem_ctrl;
  sba_pkg::sba_flag_ctrl_t       flag_ctrl;
  sba_pkg::sba_flag_stat_t       flag_stat;
  logic [WORD_W-1:0]             map_addr;
  logic [sba_pkg::WORD_BITS-1:0] map_wdata;
  logic [sba_pkg::WORD_BITS-1:0] map_rdata;
  logic [SW_W-1:0]               sum_addr;
  logic [sba_pkg::WORD_BITS-1:0] sum_wdata;
  logic [sba_pkg::WORD_BITS-1:0] sum_rdata;
  logic [SW_W-1:0]               flag_grp;
  logic [SW_W-1:0]               hit_grp;

  logic [sba_pkg::ADDR_W-1:0]    managed;
  logic [sba_pkg::ADDR_W-1:0]    sectors_ext;
  sba_pkg::sba_fz_t              fz_sum;
  sba_pkg::sba_fz_t              fz_map;
  logic [sba_pkg::ADDR_W-1:0]    cand_ext;
  logic [WORD_W-1:0]             cand_word;
  logic [sba_pkg::ADDR_W-1:0]    idx_ext;
  logic [sba_pkg::WORD_BITS-1:0] new_word;
  logic [sba_pkg::WORD_BITS-1:0] new_sum;
  logic [WORD_W-1:0]             off_word;
  logic [SW_W-1:0]               off_grp;
  logic                          fin_en;
  logic [sba_pkg::ADDR_W-1:0]    fin_granted;
  logic [1:0]                    fin_status;
  logic                          out_load;
  logic                          accept;

  sba_map_store #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_map_store (
    .clk       (clk),
    .ctrl      (mem_ctrl),
    .map_addr  (map_addr),
    .map_wdata (map_wdata),
    .map_rdata (map_rdata),
    .sum_addr  (sum_addr),
    .sum_wdata (sum_wdata),
    .sum_rdata (sum_rdata)
  );

  sba_group_flags #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_group_flags (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (flag_ctrl),
    .grp     (flag_grp),
    .stat    (flag_stat),
    .hit_grp (hit_grp)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      partition_base    <= '0;
      partition_sectors <= sba_pkg::SECTORS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sba_pkg::REG_PARTITION_BASE:    partition_base    <= cfg_data;
        sba_pkg::REG_PARTITION_SECTORS: partition_sectors <= sba_pkg::SECT_CNT_W'(cfg_data);
      endcase
    end
  end

  // Clamp the managed count to the bitmap capacity.
  always_comb begin
    sectors_ext = sba_pkg::ADDR_W'(partition_sectors);
    managed     = (sectors_ext > MAX_ADDR) ? MAX_ADDR : sectors_ext;
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != sba_pkg::ST_IDLE);
  assign out_load = (state == sba_pkg::ST_DONE) && (!out_valid || !out_stall);

  // Lookups on the freshly read words
  always_comb begin
    fz_sum    = sba_pkg::first_zero(sum_rdata);
    fz_map    = sba_pkg::first_zero(map_rdata);
    cand_ext  = sba_pkg::ADDR_W'({grp, fz_sum.pos});
    cand_word = WORD_W'({grp, fz_sum.pos});
    idx_ext   = sba_pkg::ADDR_W'({word, fz_map.pos});
    new_word  = map_rdata | (32'b1 << fz_map.pos);
    new_sum   = sum_word | (32'b1 << sba_pkg::POS_W'(word));
    off_word  = WORD_W'(off >> 5);
    off_grp   = SW_W'(off_word >> 5);
  end

  // Next state, memory and flag control
  always_comb begin
    state_next  = state;
    mem_ctrl    = '0;
    flag_ctrl   = '0;
    map_addr    = word;
    map_wdata   = '0;
    sum_addr    = grp;
    sum_wdata   = '0;
    flag_grp    = grp;
    fin_en      = 1'b0;
    fin_granted = '0;
    fin_status  = sba_pkg::STATUS_DONE;

    unique case (state)
      sba_pkg::ST_CLEAR: begin
        mem_ctrl.map_wr = 1'b1;
        map_addr        = clr_idx;
        if (sba_pkg::ADDR_W'(clr_idx) < SWORDS_ADDR) begin
          mem_ctrl.sum_wr = 1'b1;
          sum_addr        = SW_W'(clr_idx);
        end
        if (clr_idx == WORD_W'(WORDS - 1)) begin
          state_next = sba_pkg::ST_IDLE;
        end
      end

      sba_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (command == sba_pkg::CMD_ALLOC) begin
            flag_ctrl.start = 1'b1;
            state_next      = sba_pkg::ST_SEARCH;
          end else begin
            state_next = sba_pkg::ST_FREE_CHK;
          end
        end
      end

      sba_pkg::ST_SEARCH: begin
        if (flag_stat.hit) begin
          mem_ctrl.sum_rd = 1'b1;
          sum_addr        = hit_grp;
          state_next      = sba_pkg::ST_SUM_CHK;
        end else if (flag_stat.last) begin
          fin_en     = 1'b1;
          fin_status = sba_pkg::STATUS_FULL;
          state_next = sba_pkg::ST_DONE;
        end else begin
          flag_ctrl.advance = 1'b1;
        end
      end

      sba_pkg::ST_SUM_CHK: begin
        // Lowest non-full word; a padding word past the map means full.
        if (fz_sum.found && (cand_ext < WORDS_ADDR)) begin
          mem_ctrl.map_rd = 1'b1;
          map_addr        = cand_word;
          state_next      = sba_pkg::ST_WORD_CHK;
        end else begin
          fin_en     = 1'b1;
          fin_status = sba_pkg::STATUS_FULL;
          state_next = sba_pkg::ST_DONE;
        end
      end

      sba_pkg::ST_WORD_CHK: begin
        // Lowest free sector overall; beyond the managed count means full.
        if (fz_map.found && (idx_ext < managed)) begin
          mem_ctrl.map_wr = 1'b1;
          map_wdata       = new_word;
          if (&new_word) begin
            mem_ctrl.sum_wr = 1'b1;
            sum_wdata       = new_sum;
            if (&new_sum) begin
              flag_ctrl.set_full = 1'b1;
            end
          end
          fin_granted = partition_base + idx_ext;
          fin_status  = sba_pkg::STATUS_DONE;
        end else begin
          fin_status = sba_pkg::STATUS_FULL;
        end
        fin_en     = 1'b1;
        state_next = sba_pkg::ST_DONE;
      end

      sba_pkg::ST_FREE_CHK: begin
        if (off < managed) begin
          mem_ctrl.map_rd = 1'b1;
          mem_ctrl.sum_rd = 1'b1;
          map_addr        = off_word;
          sum_addr        = off_grp;
          state_next      = sba_pkg::ST_FREE_WR;
        end else begin
          fin_en     = 1'b1;
          fin_status = sba_pkg::STATUS_OUTSIDE;
          state_next = sba_pkg::ST_DONE;
        end
      end

      sba_pkg::ST_FREE_WR: begin
        // Clear the used bit; the word and its group are no longer full.
        mem_ctrl.map_wr    = 1'b1;
        mem_ctrl.sum_wr    = 1'b1;
        map_addr           = off_word;
        map_wdata          = map_rdata & ~(32'b1 << off[4:0]);
        sum_addr           = off_grp;
        sum_wdata          = sum_rdata & ~(32'b1 << sba_pkg::POS_W'(off_word));
        flag_ctrl.clr_full = 1'b1;
        flag_grp           = off_grp;
        fin_en             = 1'b1;
        fin_status         = sba_pkg::STATUS_DONE;
        state_next         = sba_pkg::ST_DONE;
      end

      sba_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = sba_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = sba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sba_pkg::ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == sba_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + WORD_W'(1);
      end
    end
  end

  // Working registers of the item in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      off <= sector - partition_base;
    end
    if ((state == sba_pkg::ST_SEARCH) && flag_stat.hit) begin
      grp <= hit_grp;
    end
    if (state == sba_pkg::ST_SUM_CHK) begin
      word     <= cand_word;
      sum_word <= sum_rdata;
    end
    if (fin_en) begin
      res_granted <= fin_granted;
      res_status  <= fin_status;
    end
  end

  // Output register: hold while stalled, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      granted_sector <= res_granted;
      status         <= res_status;
    end
  end

  // Checks
  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == sba_pkg::ST_SEARCH || state == sba_pkg::ST_FREE_CHK))
    else $error("accepted item did not start work");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == sba_pkg::ST_DONE)
    else $error("result shown outside the done state");

  a_free_writes_all: assert property (@(posedge clk) disable iff (rst)
    (state == sba_pkg::ST_FREE_WR) |->
      (mem_ctrl.map_wr && mem_ctrl.sum_wr && flag_ctrl.clr_full))
    else $error("free did not update every map level");

  a_full_word_summarized: assert property (@(posedge clk) disable iff (rst)
    ((state == sba_pkg::ST_WORD_CHK) && mem_ctrl.map_wr && (&map_wdata)) |->
      mem_ctrl.sum_wr)
    else $error("word became full without summary update");

endmodule
